[rtl/core/kss_pkg.sv]
package kss_pkg;

    localparam int KEEP_COUNT = 10;
    localparam int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

    typedef logic signed [31:0] value_t;
    typedef logic [IDX_W-1:0]   slot_idx_t;

    typedef enum logic [1:0] {
        OP_OFFER = 2'd0,
        OP_DUMP  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    localparam slot_idx_t LAST_SLOT = IDX_W'(KEEP_COUNT - 1);

    typedef struct packed {
        logic offer;
        logic rotate;
        logic clear;
    } cell_ctrl_t;

endpackage

[rtl/core/kss_cmd_if.sv]
interface kss_cmd_if
    import kss_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    value_t     value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

[rtl/core/kss_res_if.sv]
interface kss_res_if
    import kss_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t kept_value;
    logic   valid_res;
    logic   last;

    modport source (output valid, output kept_value, output valid_res, output last,
                    input ready);
    modport sink   (input valid, input kept_value, input valid_res, input last,
                    output ready);
endinterface

[rtl/core/kss_cell.sv]
module kss_cell
    import kss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     offer_value,
    input  logic       prev_take,
    input  value_t     prev_val,
    input  logic       prev_occ,
    input  value_t     next_val,
    input  logic       next_occ,
    output logic       take,
    output value_t     val,
    output logic       occ
);

    value_t val_reg;
    value_t val_next;
    logic   occ_reg;
    logic   occ_next;

    // empty slot or strictly larger holder takes the offer
    assign take = !occ_reg || (offer_value < val_reg);

    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        priority if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.rotate)
        begin
            val_next = next_val;
            occ_next = next_occ;
        end
        else if (ctrl.offer)
        begin
            priority if (prev_take)
            begin
                val_next = prev_val;
                occ_next = prev_occ;
            end
            else if (take)
            begin
                val_next = offer_value;
                occ_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign occ = occ_reg;

endmodule

[rtl/core/streaming_k_smallest_selector_top.sv]
// channel | dir | fields                             | transaction
// cmd     | in  | opcode[1:0], value[31:0]           | offer, dump or clear
// res     | out | kept_value[31:0], valid_res, last  | one slot of a dump
// offer, clear and unused opcode: taken whenever no dump runs, no result
// dump: KEEP_COUNT results, one per cycle, by rotating the cell chain once round
// cmd is held off while a dump rotates; result stalls pause the rotation
// reset clears all occupancy flags and the dump sequencer
module streaming_k_smallest_selector_top
    import kss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kss_cmd_if.sink   cmd,
    kss_res_if.source res
);

    logic                  dumping_reg;
    logic                  dumping_next;
    slot_idx_t             dump_idx_reg;
    slot_idx_t             dump_idx_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    value_t                res_value_reg;
    value_t                res_value_next;
    logic                  res_vres_reg;
    logic                  res_vres_next;
    logic                  res_last_reg;
    logic                  res_last_next;

    logic                  cmd_fire;
    logic                  out_free;
    cell_ctrl_t            ctrl;
    logic [KEEP_COUNT-1:0] take_vec;
    logic [KEEP_COUNT-1:0] occ_vec;
    value_t                val_arr [KEEP_COUNT];

    assign cmd.ready = !dumping_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !res_valid_reg || res.ready;

    assign ctrl.offer  = cmd_fire && (cmd.opcode == OP_OFFER);
    assign ctrl.clear  = cmd_fire && (cmd.opcode == OP_CLEAR);
    assign ctrl.rotate = dumping_reg && out_free;

    for (genvar i = 0; i < KEEP_COUNT; i++)
    begin : g_cell
        kss_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .offer_value (cmd.value),
            .prev_take   ((i == 0) ? 1'b0 : take_vec[(i == 0) ? 0 : i - 1]),
            .prev_val    (val_arr[(i == 0) ? 0 : i - 1]),
            .prev_occ    ((i == 0) ? 1'b0 : occ_vec[(i == 0) ? 0 : i - 1]),
            .next_val    (val_arr[(i + 1) % KEEP_COUNT]),
            .next_occ    (occ_vec[(i + 1) % KEEP_COUNT]),
            .take        (take_vec[i]),
            .val         (val_arr[i]),
            .occ         (occ_vec[i])
        );
    end

    always_comb
    begin
        dumping_next   = dumping_reg;
        dump_idx_next  = dump_idx_reg;
        res_valid_next = res_valid_reg;
        res_value_next = res_value_reg;
        res_vres_next  = res_vres_reg;
        res_last_next  = res_last_reg;
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (ctrl.rotate)
        begin
            res_valid_next = 1'b1;
            res_value_next = occ_vec[0] ? val_arr[0] : '0;
            res_vres_next  = occ_vec[0];
            res_last_next  = (dump_idx_reg == LAST_SLOT);
            if (dump_idx_reg == LAST_SLOT)
            begin
                dumping_next = 1'b0;
            end
            else
            begin
                dump_idx_next = dump_idx_reg + 1'b1;
            end
        end
        if (cmd_fire && (cmd.opcode == OP_DUMP))
        begin
            dumping_next  = 1'b1;
            dump_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dumping_reg   <= 1'b0;
            dump_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            dumping_reg   <= dumping_next;
            dump_idx_reg  <= dump_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_vres_reg  <= res_vres_next;
        res_last_reg  <= res_last_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.kept_value = res_value_reg;
    assign res.valid_res  = res_vres_reg;
    assign res.last       = res_last_reg;

`ifndef SYNTH
    // the prefix is rotated out of place while a dump runs
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        !dumping_reg |-> ((occ_vec & (occ_vec + 1'b1)) == '0))
        else $error("occupied cells not a contiguous prefix");

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.rotate && dump_idx_reg == LAST_SLOT) |=> !dumping_reg)
        else $error("dump sequencer ran past the last slot");

    a_no_update_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        dumping_reg |-> (!ctrl.offer && !ctrl.clear))
        else $error("chain modified during dump rotation");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (occ_vec == '0))
        else $error("clear left occupied cells");

    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.valid_res) |-> (res.kept_value == '0))
        else $error("empty slot carries a nonzero value");
`endif

endmodule
